>>> rtl/enx_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, types and rounding helpers of the envelope expander.
package enx_pkg;

    localparam int CHANNELS  = 2;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int COEF_W    = 16;
    localparam int ENV_W     = 23;
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int IN_DATA_W = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [SAMPLE_W-1:0] SMAX_S = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SMIN_S = 24'sh800000;
    localparam logic [ENV_W-1:0]           ENV_MAX = 23'h7FFFFF;
    localparam logic [SAMPLE_W-1:0]        UNITY   = 24'h800000;

    localparam logic signed [PROD_W-1:0] PROD_SMAX  = 50'sd8388607;
    localparam logic signed [PROD_W-1:0] PROD_SMIN  = -50'sd8388608;
    localparam logic signed [PROD_W-1:0] PROD_UNITY = 50'sd8388608;
    localparam logic signed [PROD_W-1:0] PROD_EMAX  = 50'sd8388607;

    localparam logic [COEF_W-1:0] ATTACK_RST  = 16'd1357;
    localparam logic [COEF_W-1:0] RELEASE_RST = 16'd9;
    localparam logic [COEF_W-1:0] THR_RST     = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_RELEASE = 2'd1,
        CFG_THR     = 2'd2,
        CFG_BYPASS  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MOP_GAIN = 3'd0,
        MOP_ENV  = 3'd1,
        MOP_THR  = 3'd2,
        MOP_SQ   = 3'd3,
        MOP_OUT  = 3'd4
    } mul_op_t;

    typedef struct packed {
        logic [COEF_W-1:0] attack;
        logic [COEF_W-1:0] release_c;
        logic [COEF_W-1:0] thr;
        logic              bypass;
    } enx_cfg_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        mul_op_t mul_op;
        logic    scale_en;
        logic    diff_en;
        logic    env_en;
        logic    open_en;
        logic    sq_en;
        logic    out_load;
    } enx_cmd_t;

    // round half up: add half, then floor through an arithmetic shift
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] x,
        input int unsigned              n
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] sum;
        half = PROD_W'(1) <<< (n - 1);
        sum  = x + half;
        return sum >>> n;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(
        input logic signed [PROD_W-1:0] x
    );
        logic signed [SAMPLE_W-1:0] r;
        if (x > PROD_SMAX)
            r = SMAX_S;
        else if (x < PROD_SMIN)
            r = SMIN_S;
        else
            r = x[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/envelope_noise_expander.sv
`timescale 1ns / 1ps
// Top level: configuration registers, sequencer and datapath of the envelope expander.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready    | tdata: sample_in[23:0], gain[39:24]
//          |     |                         | tuser: channel
//  m_axis  | out | m_axis_tvalid/tready    | tdata: sample_out[23:0]; tuser: channel_out
//  cfg     | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data (always ready)
//
// Between its transaction and the next input, a gated sample steps through the
// sequencer: five products go through one shared 25x25 multiplier, each followed by a
// step of rounding and clamping. A bypassed sample goes straight to the write step.
// Reset clears the envelope of every channel and loads the register defaults.
// A result waits in the output register while the next sample is taken; the
// write step stalls only when a previous result is still unclaimed.
module envelope_noise_expander
    import enx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // sample_in[23:0], gain[39:24]
    input  logic [0:0]           s_axis_tuser,   // channel[0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [SAMPLE_W-1:0]  m_axis_tdata,   // sample_out[23:0]
    output logic [0:0]           m_axis_tuser,   // channel_out[0]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    enx_cfg_t cfg_reg;
    enx_cmd_t cmd;
    logic     out_user;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack    <= ATTACK_RST;
            cfg_reg.release_c <= RELEASE_RST;
            cfg_reg.thr       <= THR_RST;
            cfg_reg.bypass    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ATTACK:  cfg_reg.attack    <= cfg_data;
                CFG_RELEASE: cfg_reg.release_c <= cfg_data;
                CFG_THR:     cfg_reg.thr       <= cfg_data;
                CFG_BYPASS:  cfg_reg.bypass    <= cfg_data[0];
                default:     cfg_reg.bypass    <= cfg_reg.bypass;
            endcase
        end
    end

    enx_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .bypass  (cfg_reg.bypass),
        .cmd     (cmd)
    );

    enx_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser[0]),
        .out_data (m_axis_tdata),
        .out_user (out_user)
    );

    assign m_axis_tuser[0] = out_user;

endmodule

>>> rtl/enx_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps one sample through the shared multiplier and owns both handshakes.
module enx_ctrl
    import enx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  logic     bypass,
    output enx_cmd_t cmd
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_MUL_GAIN = 12'b0000_0000_0010,
        ST_SCALE    = 12'b0000_0000_0100,
        ST_DIFF     = 12'b0000_0000_1000,
        ST_MUL_ENV  = 12'b0000_0001_0000,
        ST_UPDATE   = 12'b0000_0010_0000,
        ST_MUL_THR  = 12'b0000_0100_0000,
        ST_OPEN     = 12'b0000_1000_0000,
        ST_MUL_SQ   = 12'b0001_0000_0000,
        ST_SQUARE   = 12'b0010_0000_0000,
        ST_MUL_OUT  = 12'b0100_0000_0000,
        ST_WRITE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.mul_op = MOP_GAIN;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = bypass ? ST_WRITE : ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_GAIN;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = ST_MUL_ENV;
            end
            ST_MUL_ENV:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_ENV;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.env_en = 1'b1;
                state_next = ST_MUL_THR;
            end
            ST_MUL_THR:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_THR;
                state_next = ST_OPEN;
            end
            ST_OPEN:
            begin
                cmd.open_en = 1'b1;
                state_next  = ST_MUL_SQ;
            end
            ST_MUL_SQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_SQ;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.sq_en  = 1'b1;
                state_next = ST_MUL_OUT;
            end
            ST_MUL_OUT:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_OUT;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the output register is free or drains this cycle
                if (!m_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_bypass_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready && bypass) |=> (state_reg == ST_WRITE))
        else $error("bypass transaction did not go straight to write");

    a_gate_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_ready && !bypass) |=> (state_reg == ST_MUL_GAIN))
        else $error("gated transaction did not start the multiply chain");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before its transaction completed");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("loaded result not presented");

endmodule

>>> rtl/enx_dp.sv
`timescale 1ns / 1ps
// Datapath: sample registers, shared 25x25 multiplier, envelope store and output register.
module enx_dp
    import enx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  enx_cmd_t             cmd,
    input  enx_cfg_t             cfg,
    input  logic [IN_DATA_W-1:0] in_data,
    input  logic                 in_user,
    output logic [SAMPLE_W-1:0]  out_data,
    output logic                 out_user
);

    logic signed [SAMPLE_W-1:0] x_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic                       ch_reg;
    logic [CH_IDX_W-1:0]        idx_reg;
    logic                       byp_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic [ENV_W-1:0]           a_reg;
    logic signed [SAMPLE_W-1:0] diff_reg;
    logic [COEF_W-1:0]          coef_reg;
    logic [ENV_W-1:0]           env_reg;
    logic [SAMPLE_W-1:0]        t_reg;
    logic [SAMPLE_W-1:0]        t2_reg;
    logic [ENV_W-1:0]           env_mem_reg [CHANNELS];
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_user_reg;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [SAMPLE_W-1:0] v_next;
    logic [ENV_W-1:0]           a_next;
    logic [ENV_W-1:0]           env_cur;
    logic signed [SAMPLE_W-1:0] diff_next;
    logic signed [PROD_W-1:0]   env_sum;
    logic [ENV_W-1:0]           env_next;
    logic signed [PROD_W-1:0]   t_full;
    logic [SAMPLE_W-1:0]        t_next;
    logic signed [PROD_W-1:0]   t2_full;
    logic signed [SAMPLE_W-1:0] y_next;
    logic [CH_IDX_W-1:0]        idx_in;

    // channels past the store fall back to channel 0
    assign idx_in = (CH_IDX_W'(in_user) < CH_IDX_W'(CHANNELS - 1) ||
                     CH_IDX_W'(in_user) == CH_IDX_W'(CHANNELS - 1))
                    ? CH_IDX_W'(in_user) : '0;

    always_comb
    begin
        case (cmd.mul_op)
            MOP_GAIN:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(gain_reg);
            end
            MOP_ENV:
            begin
                mul_a = MUL_W'(coef_reg);
                mul_b = MUL_W'(diff_reg);
            end
            MOP_THR:
            begin
                mul_a = MUL_W'(env_reg);
                mul_b = MUL_W'(cfg.thr);
            end
            MOP_SQ:
            begin
                mul_a = MUL_W'(t_reg);
                mul_b = MUL_W'(t_reg);
            end
            MOP_OUT:
            begin
                mul_a = MUL_W'(v_reg);
                mul_b = MUL_W'(t2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // scaled sample and its clipped magnitude
    always_comb
    begin
        v_next = sat24(rnd_shift(prod_reg, 12));
        if (v_next == SMIN_S)
            a_next = ENV_MAX;
        else if (v_next < 0)
            a_next = ENV_W'(-v_next);
        else
            a_next = v_next[ENV_W-1:0];
    end

    assign env_cur   = env_mem_reg[idx_reg];
    assign diff_next = SAMPLE_W'(signed'({1'b0, a_reg})) - SAMPLE_W'(signed'({1'b0, env_cur}));

    always_comb
    begin
        env_sum = PROD_W'(signed'({1'b0, env_reg})) + rnd_shift(prod_reg, 16);
        if (env_sum < 0)
            env_next = '0;
        else if (env_sum > PROD_EMAX)
            env_next = ENV_MAX;
        else
            env_next = env_sum[ENV_W-1:0];
    end

    always_comb
    begin
        t_full = rnd_shift(prod_reg, 8);
        if (t_full > PROD_UNITY)
            t_next = UNITY;
        else
            t_next = t_full[SAMPLE_W-1:0];
    end

    assign t2_full = rnd_shift(prod_reg, 23);
    assign y_next  = sat24(rnd_shift(prod_reg, 23));

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg    <= in_data[SAMPLE_W-1:0];
            gain_reg <= in_data[SAMPLE_W+GAIN_W-1:SAMPLE_W];
            ch_reg   <= in_user;
            idx_reg  <= idx_in;
            byp_reg  <= cfg.bypass;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.scale_en)
        begin
            v_reg <= v_next;
            a_reg <= a_next;
        end
        if (cmd.diff_en)
        begin
            diff_reg <= diff_next;
            env_reg  <= env_cur;
            coef_reg <= (a_reg > env_cur) ? cfg.attack : cfg.release_c;
        end
        if (cmd.env_en)
            env_reg <= env_next;
        if (cmd.open_en)
            t_reg <= t_next;
        if (cmd.sq_en)
            t2_reg <= t2_full[SAMPLE_W-1:0];
        if (cmd.out_load)
        begin
            out_data_reg <= byp_reg ? x_reg : y_next;
            out_user_reg <= ch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                env_mem_reg[i] <= '0;
        end
        else if (cmd.env_en)
        begin
            env_mem_reg[idx_reg] <= env_next;
        end
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

    a_open_limited: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.open_en |=> (t_reg <= UNITY))
        else $error("opening factor above unity");

    a_square_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sq_en |=> (t2_reg <= t_reg))
        else $error("squared opening factor exceeds opening factor");

endmodule
